[rtl/ftach_pkg.sv]
// ftach_pkg: shared constants, register indexes and types for the fan tachometer.
// No dependencies; imported by every module of the block.
package ftach_pkg;

  localparam int CHANNELS           = 4;
  localparam int PULSES_PER_MEASURE = 4;

  localparam int CH_W    = 2;
  localparam int TIME_W  = 32;
  localparam int RPM_W   = 16;
  localparam int SEL_W   = 3;
  localparam int SP_W    = 11;
  localparam int DB_W    = 10;
  localparam int SCALE_W = 20;
  localparam int NUM_SP  = 4;
  localparam int CNT_W   = $clog2(PULSES_PER_MEASURE + 1);
  localparam int CFG_W   = 3;

  localparam logic [DB_W-1:0]    DEADBAND_RST = DB_W'(150);
  localparam logic [SCALE_W-1:0] SCALE_RST    = SCALE_W'(120000);
  localparam logic [RPM_W-1:0]   RPM_MAX      = '1;

  // configuration register indexes
  localparam logic [CFG_W-1:0] REG_SEL   = 3'd0;
  localparam logic [CFG_W-1:0] REG_SP0   = 3'd1;
  localparam logic [CFG_W-1:0] REG_SP1   = 3'd2;
  localparam logic [CFG_W-1:0] REG_SP2   = 3'd3;
  localparam logic [CFG_W-1:0] REG_SP3   = 3'd4;
  localparam logic [CFG_W-1:0] REG_DB    = 3'd5;
  localparam logic [CFG_W-1:0] REG_SCALE = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } seq_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[rtl/ftach_div.sv]
// ftach_div: restoring divider, one quotient bit per cycle (rpm_scale / interval).
// Depends on ftach_pkg.
module ftach_div
  import ftach_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SCALE_W-1:0] dividend,
  input  logic [TIME_W-1:0]  divisor,
  output div_stat_t          stat,
  output logic [SCALE_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SCALE_W);

  logic [SCALE_W-1:0] dvd_r, dvd_nxt;
  logic [TIME_W-1:0]  rem_r, rem_nxt;
  logic [TIME_W-1:0]  dvs_r;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [TIME_W:0]    trial;
  logic               qbit;

  assign trial = {rem_r, dvd_r[SCALE_W-1]};
  assign qbit  = trial >= {1'b0, dvs_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      step_nxt = STEP_W'(SCALE_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[SCALE_W-2:0], qbit};
      rem_nxt = qbit ? TIME_W'(trial - {1'b0, dvs_r}) : trial[TIME_W-1:0];
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dvd_r;

endmodule

[rtl/fan_tach_rpm_with_deadband.sv]
// fan_tach_rpm_with_deadband: top level, four-channel tachometer with display deadband.
// Depends on ftach_pkg and ftach_div.
//
// Each input transaction is one tach edge on a channel, stamped with a millisecond
// time. A channel's PULSES_PER_MEASURE-th edge ends a measurement: the time since that
// channel's previous measurement (modulo 2^32) divides rpm_scale, the quotient
// saturates at 65535, and one output transaction is produced. A zero interval keeps
// the old rpm and flags zero_interval. For the selected channel the shown speed is
// refreshed: the setpoint when |rpm - setpoint| < deadband and the setpoint was not
// changed recently, the raw rpm otherwise. Edges that do not complete a measurement
// produce nothing. A measurement is accepted, divided in the bit-serial divider (one
// quotient bit of the 20-bit scale per cycle), its rpm written back and the output
// register loaded; a zero interval skips the divider. After acceptance in_stall is
// high until the output register is loaded. The result sits in an output register,
// so the next edge can be taken while it waits for the consumer. The user must write
// configuration via cfg_we/cfg_index/cfg_wdata while idle; the block does not check.
module fan_tach_rpm_with_deadband
  import ftach_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_index,
  input  logic [SCALE_W-1:0] cfg_wdata,
  // tach edges
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CH_W-1:0]    in_channel,
  input  logic [TIME_W-1:0]  in_now_ms,
  input  logic               in_setpoint_recent,
  // measurements
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CH_W-1:0]    out_channel,
  output logic [RPM_W-1:0]   out_measured_rpm,
  output logic               out_zero_interval,
  output logic               out_shown_updated,
  output logic [RPM_W-1:0]   out_shown_speed
);

  // configuration registers
  logic [SEL_W-1:0]   sel_r;
  logic [SP_W-1:0]    setpoint_r [NUM_SP];
  logic [DB_W-1:0]    deadband_r;
  logic [SCALE_W-1:0] scale_r;

  // per-channel state
  logic [CNT_W-1:0]  pulse_cnt_r [CHANNELS];
  logic [TIME_W-1:0] last_time_r [CHANNELS];
  logic [RPM_W-1:0]  last_rpm_r  [CHANNELS];
  logic [RPM_W-1:0]  shown_r;

  // sequencer
  seq_state_t      state_r, state_nxt;
  logic [CH_W-1:0] ch_r;
  logic            recent_r;
  logic            zero_r;

  // output register
  logic             out_valid_r;
  logic [CH_W-1:0]  out_channel_r;
  logic [RPM_W-1:0] out_rpm_r;
  logic             out_zero_r;
  logic             out_upd_r;
  logic [RPM_W-1:0] out_shown_r;

  // datapath
  logic               in_acc;
  logic [CNT_W-1:0]   cnt_inc;
  logic               ch_ok;
  logic               meas_hit;
  logic [TIME_W-1:0]  interval;
  logic               interval_zero;
  logic               div_start;
  logic               load_out;
  div_stat_t          div_stat;
  logic [SCALE_W-1:0] quot;
  logic [RPM_W-1:0]   quot_sat;
  logic [RPM_W-1:0]   rpm_cur;
  logic [RPM_W-1:0]   sp_cur;
  logic [RPM_W-1:0]   diff;
  logic               selected;
  logic [RPM_W-1:0]   shown_new;

  assign in_acc        = in_valid && !in_stall;
  assign ch_ok         = 32'(in_channel) < CHANNELS;
  assign cnt_inc       = pulse_cnt_r[in_channel] + 1'b1;
  assign meas_hit      = ch_ok && (cnt_inc >= CNT_W'(PULSES_PER_MEASURE));
  assign interval      = in_now_ms - last_time_r[in_channel];
  assign interval_zero = interval == '0;

  ftach_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (scale_r),
    .divisor  (interval),
    .stat     (div_stat),
    .quotient (quot)
  );

  assign quot_sat = (quot > SCALE_W'(RPM_MAX)) ? RPM_MAX : quot[RPM_W-1:0];

  // shown-speed decision, valid while in ST_OUT
  assign rpm_cur = last_rpm_r[ch_r];
  assign sp_cur  = RPM_W'(setpoint_r[ch_r]);
  assign diff    = (rpm_cur > sp_cur) ? (rpm_cur - sp_cur) : (sp_cur - rpm_cur);

  // selector 0 and 1 both pick channel 0; codes past the last channel pick none
  always_comb begin
    if (sel_r <= SEL_W'(1)) begin
      selected = ch_r == '0;
    end else if (sel_r <= SEL_W'(NUM_SP)) begin
      selected = SEL_W'(ch_r) == (sel_r - 1'b1);
    end else begin
      selected = 1'b0;
    end
  end

  assign shown_new = selected ? ((!recent_r && (diff < RPM_W'(deadband_r))) ? sp_cur : rpm_cur)
                              : shown_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && meas_hit) begin
          state_nxt = interval_zero ? ST_OUT : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs; in ST_IDLE the input is never stalled, so valid means accepted
  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        div_start = in_valid && meas_hit && !interval_zero;
      end
      ST_DIV: begin
        in_stall = 1'b1;
      end
      ST_OUT: begin
        load_out = !out_valid_r || !out_stall;
      end
      default: in_stall = 1'b1;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      sel_r       <= '0;
      deadband_r  <= DEADBAND_RST;
      scale_r     <= SCALE_RST;
      shown_r     <= '0;
      for (int i = 0; i < NUM_SP; i++) begin
        setpoint_r[i] <= '0;
      end
      for (int i = 0; i < CHANNELS; i++) begin
        pulse_cnt_r[i] <= '0;
        last_time_r[i] <= '0;
        last_rpm_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          REG_SEL:   sel_r         <= cfg_wdata[SEL_W-1:0];
          REG_SP0:   setpoint_r[0] <= cfg_wdata[SP_W-1:0];
          REG_SP1:   setpoint_r[1] <= cfg_wdata[SP_W-1:0];
          REG_SP2:   setpoint_r[2] <= cfg_wdata[SP_W-1:0];
          REG_SP3:   setpoint_r[3] <= cfg_wdata[SP_W-1:0];
          REG_DB:    deadband_r    <= cfg_wdata[DB_W-1:0];
          REG_SCALE: scale_r       <= cfg_wdata;
          default: ;
        endcase
      end

      if (in_acc && ch_ok) begin
        pulse_cnt_r[in_channel] <= meas_hit ? '0 : cnt_inc;
        if (meas_hit) begin
          last_time_r[in_channel] <= in_now_ms;
        end
      end

      if (state_r == ST_DIV && div_stat.done) begin
        last_rpm_r[ch_r] <= quot_sat;
      end

      if (load_out) begin
        shown_r <= shown_new;
      end
    end
  end

  // transaction payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc && meas_hit) begin
      ch_r     <= in_channel;
      recent_r <= in_setpoint_recent;
      zero_r   <= interval_zero;
    end
    if (load_out) begin
      out_channel_r <= ch_r;
      out_rpm_r     <= rpm_cur;
      out_zero_r    <= zero_r;
      out_upd_r     <= selected;
      out_shown_r   <= shown_new;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_channel       = out_channel_r;
  assign out_measured_rpm  = out_rpm_r;
  assign out_zero_interval = out_zero_r;
  assign out_shown_updated = out_upd_r;
  assign out_shown_speed   = out_shown_r;

endmodule

[rtl/ftach_chk.sv]
// ftach_chk: port-level checks for fan_tach_rpm_with_deadband, bound to the top level.
// Depends on ftach_pkg.
module ftach_chk
  import ftach_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [CH_W-1:0]    out_channel,
  input logic [RPM_W-1:0]   out_measured_rpm,
  input logic [RPM_W-1:0]   out_shown_speed
);

  // a pending result is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_channel) && $stable(out_measured_rpm)
                               && $stable(out_shown_speed))
    else $error("stalled result changed");

  // a fresh result only follows a cycle in which the block was busy measuring
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a measurement in flight");

  // leaving reset the block is idle and has nothing to deliver
  a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_stall && !out_valid)
    else $error("not idle after reset");

endmodule

bind fan_tach_rpm_with_deadband ftach_chk u_ftach_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_channel      (out_channel),
  .out_measured_rpm (out_measured_rpm),
  .out_shown_speed  (out_shown_speed)
);
